@@ src/hsbp_pkg.sv @@
// ----------------------------------------------------------------------------
// hsbp_pkg
// Shared types and constants of the Huffman symbol bit packer.
// ----------------------------------------------------------------------------
package hsbp_pkg;

    localparam int HSBP_MAX_CODE_LEN = 32;
    localparam int HSBP_SYMBOLS      = 256;

    localparam int REQ_W   = 2;
    localparam int SYM_IN_W = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PART_W  = 7;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = BYTE_W + CODE_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } pack_state_t;

    // request from the packer to the code table
    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [SYM_IN_W-1:0] index;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    length;
    } tbl_req_t;

    // lookup answer, in the cycle after the read; length zero means no code
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } tbl_rsp_t;

endpackage

@@ src/hsbp_req_if.sv @@
// ----------------------------------------------------------------------------
// hsbp_req_if
// Request channel: table loads, symbols to encode and flushes.
// ----------------------------------------------------------------------------
interface hsbp_req_if
    import hsbp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [SYM_IN_W-1:0] symbol;
    logic [CODE_W-1:0]   code_value;
    logic [LEN_W-1:0]    code_length;

    modport source (output valid, output req_type, output symbol, output code_value,
                    output code_length, input ready);
    modport sink   (input valid, input req_type, input symbol, input code_value,
                    input code_length, output ready);
endinterface

@@ src/hsbp_res_if.sv @@
// ----------------------------------------------------------------------------
// hsbp_res_if
// Result channel: packed bytes, last marks the padded flush byte.
// ----------------------------------------------------------------------------
interface hsbp_res_if
    import hsbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ src/huffman_symbol_bit_packer.sv @@
// ----------------------------------------------------------------------------
// huffman_symbol_bit_packer
// Huffman encoding stage: code table lookup and MSB-first byte packing.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, symbol, code_value, code_length
//  res      out  valid/ready    out_byte, last
//
//  A load is written to the table from the idle state. An encode reads the
//  table through the RAM's registered port, then aligns the code and emits
//  each complete word through the one-word output register; a flush with
//  pending bits emits one padded word.
//  Reset clears the entry valid bits, the pending bits and the output valid
//  at once; no clearing pass over the RAM is needed.
//  A stalled result holds the packer in its emit state; a new request is
//  taken while the last word of the previous one still waits.
//
module huffman_symbol_bit_packer
    import hsbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = HSBP_MAX_CODE_LEN,
    parameter int SYMBOLS      = HSBP_SYMBOLS
) (
    input  logic       clk,
    input  logic       rst_n,
    hsbp_req_if.sink   req,
    hsbp_res_if.source res
);
    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;

    // code and length store, valid bit per entry, length clamp on load
    hsbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .tbl_req (tbl_req),
        .tbl_rsp (tbl_rsp)
    );

    // sequencing, bit accumulation and word output
    hsbp_packer u_packer (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .tbl_req (tbl_req),
        .tbl_rsp (tbl_rsp)
    );
endmodule

@@ src/hsbp_ram.sv @@
// ----------------------------------------------------------------------------
// hsbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/hsbp_table.sv @@
// ----------------------------------------------------------------------------
// hsbp_table
// Code table: RAM of codes and lengths, with one valid bit per entry.
// ----------------------------------------------------------------------------
module hsbp_table
    import hsbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = HSBP_MAX_CODE_LEN,
    parameter int SYMBOLS      = HSBP_SYMBOLS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t tbl_req,
    output tbl_rsp_t tbl_rsp
);
    localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam logic [SYM_IN_W:0] SYM_LIMIT = (SYM_IN_W + 1)'(SYMBOLS);
    localparam logic [LEN_W-1:0]  LEN_LIMIT =
        LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

    logic [AW-1:0]           idx;
    logic                    in_range;
    logic                    we;
    logic [LEN_W-1:0]        len_clamped;
    logic [CODE_W+LEN_W-1:0] rdata;
    logic [SYMBOLS-1:0]      valid_reg;
    logic [SYMBOLS-1:0]      valid_next;
    logic                    hit_reg;
    logic                    hit_next;

    assign idx         = tbl_req.index[AW-1:0];
    assign in_range    = {1'b0, tbl_req.index} < SYM_LIMIT;
    assign we          = tbl_req.wr && in_range;
    assign len_clamped = (tbl_req.length > LEN_LIMIT) ? LEN_LIMIT : tbl_req.length;

    hsbp_ram #(
        .WIDTH (CODE_W + LEN_W),
        .DEPTH (SYMBOLS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (idx),
        .wdata ({tbl_req.code, len_clamped}),
        .raddr (idx),
        .rdata (rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[idx] = 1'b1;
        end
        hit_next = tbl_req.rd && in_range && valid_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    // an entry never loaded, or out of range, reads as having no code
    assign tbl_rsp.code   = rdata[CODE_W+LEN_W-1:LEN_W];
    assign tbl_rsp.length = hit_reg ? rdata[LEN_W-1:0] : '0;
endmodule

@@ src/hsbp_packer.sv @@
// ----------------------------------------------------------------------------
// hsbp_packer
// Request sequencer, bit accumulator and output word register.
// ----------------------------------------------------------------------------
module hsbp_packer
    import hsbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsbp_req_if.sink   req,
    hsbp_res_if.source res,
    output tbl_req_t   tbl_req,
    input  tbl_rsp_t   tbl_rsp
);
    localparam logic [LEN_W-1:0] TOTAL_BYTE = LEN_W'(BYTE_W);

    pack_state_t       state_reg, state_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic              last_reg, last_next;
    logic [PART_W-1:0] partial_reg, partial_next;   // pending bits, left aligned
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              slot_free;
    logic              emit_go;
    logic [CODE_W-1:0] aligned;
    logic [LEN_W-1:0]  shift_amt;
    logic [ACC_W-1:0]  acc_lookup;
    logic [LEN_W-1:0]  total_lookup;
    logic [ACC_W-1:0]  acc_shift;
    logic [LEN_W-1:0]  total_rem;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || res.ready;
    assign emit_go   = (state_reg == ST_EMIT) && slot_free;

    assign tbl_req.wr     = accept && (req.req_type == REQ_LOAD);
    assign tbl_req.rd     = accept && (req.req_type == REQ_ENCODE);
    assign tbl_req.index  = req.symbol;
    assign tbl_req.code   = req.code_value;
    assign tbl_req.length = req.code_length;

    // left-align the code, dropping bits above its length, then append it
    assign shift_amt    = LEN_W'(CODE_W) - tbl_rsp.length;
    assign aligned      = tbl_rsp.code << shift_amt;
    assign acc_lookup   = {partial_reg, 1'b0, {CODE_W{1'b0}}}
                        | ({aligned, {BYTE_W{1'b0}}} >> count_reg);
    assign total_lookup = LEN_W'(count_reg) + tbl_rsp.length;
    assign acc_shift    = acc_reg << BYTE_W;
    assign total_rem    = total_reg - TOTAL_BYTE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_ENCODE))
                begin
                    state_next = ST_LOOKUP;
                end
                else if (accept && (req.req_type == REQ_FLUSH) && (count_reg != '0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LOOKUP:
            begin
                state_next = (total_lookup >= TOTAL_BYTE) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go && (total_rem < TOTAL_BYTE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        acc_next       = acc_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        partial_next   = partial_reg;
        count_next     = count_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !res.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_FLUSH))
                begin
                    acc_next   = {partial_reg, 1'b0, {CODE_W{1'b0}}};
                    total_next = TOTAL_BYTE;
                    last_next  = 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                acc_next   = acc_lookup;
                total_next = total_lookup;
                last_next  = 1'b0;
                if (total_lookup < TOTAL_BYTE)
                begin
                    partial_next = acc_lookup[ACC_W-1 -: PART_W];
                    count_next   = total_lookup[CNT_W-1:0];
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_byte_next  = acc_reg[ACC_W-1 -: BYTE_W];
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    acc_next       = acc_shift;
                    total_next     = total_rem;
                    if (total_rem < TOTAL_BYTE)
                    begin
                        partial_next = acc_shift[ACC_W-1 -: PART_W];
                        count_next   = total_rem[CNT_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            partial_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        total_reg    <= total_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.last     = out_last_reg;
endmodule

@@ src/hsbp_checker.sv @@
// ----------------------------------------------------------------------------
// hsbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hsbp_checker
    import hsbp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic [REQ_W-1:0]  req_type,
    input logic              res_valid,
    input logic              res_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              last
);
    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(last))
        else $error("result word changed while stalled");

    // an encode always waits for the table read
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_ENCODE) |=> !req_ready)
        else $error("request taken during table lookup");

    // a load produces no word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_LOAD) && !res_valid |=> !res_valid)
        else $error("word produced by a table load");
endmodule

bind huffman_symbol_bit_packer hsbp_checker u_hsbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .out_byte  (res.out_byte),
    .last      (res.last)
);
